// ----- rtl/bsiq_pkg.sv -----
// bsiq_pkg: shared types and constants for the bounded sorted insert queue.
// Used by bsiq_cell and bounded_sorted_insert_queue; no dependencies.
package bsiq_pkg;

   localparam int QUEUE_BITS_DEF = 3;
   localparam int KEY_W = 32;
   localparam int POS_W = 24;
   localparam int DIST_W = 24;
   localparam int CMD_W = 2;
   localparam int RANK_W = 3;
   localparam int COUNT_W = 4;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH = 2'd0,
      CMD_CLEAR = 2'd1,
      CMD_READ = 2'd2
   } cmd_type;

   typedef struct packed {
      logic signed [KEY_W-1:0] key;
      logic [POS_W-1:0] position;
      logic [DIST_W-1:0] dist_a;
      logic [DIST_W-1:0] dist_b;
      logic [DIST_W-1:0] dist_c;
      logic [DIST_W-1:0] dist_d;
   } entry_type;

   // hand-off from one cell to the next
   typedef struct packed {
      logic lt;
      entry_type entry;
   } link_type;

   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic [RANK_W-1:0] rank;
      logic signed [KEY_W-1:0] key;
      logic [POS_W-1:0] position;
      logic [DIST_W-1:0] dist_a;
      logic [DIST_W-1:0] dist_b;
      logic [DIST_W-1:0] dist_c;
      logic [DIST_W-1:0] dist_d;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic hit;
      logic signed [KEY_W-1:0] out_key;
      logic [POS_W-1:0] out_position;
      logic [DIST_W-1:0] out_dist_a;
      logic [DIST_W-1:0] out_dist_b;
      logic [DIST_W-1:0] out_dist_c;
      logic [DIST_W-1:0] out_dist_d;
   } rsp_type;

endpackage

// ----- rtl/bsiq_cell.sv -----
// bsiq_cell: one rank of the sorted queue, compare-and-shift storage cell.
// Depends on bsiq_pkg.
module bsiq_cell (
   input  logic                clock,
   input  logic                push,
   input  logic                valid,
   input  logic                keep_ok,
   input  bsiq_pkg::entry_type new_entry,
   input  bsiq_pkg::link_type  prev_link,
   output bsiq_pkg::link_type  link,
   output bsiq_pkg::entry_type entry
);

   bsiq_pkg::entry_type entry_ff;
   bsiq_pkg::entry_type entry_in;
   logic                own_lt;

   assign own_lt = valid && (entry_ff.key < new_entry.key);

   always_comb begin
      entry_in = entry_ff;
      if (push) begin
         if (prev_link.lt) begin
            if (!(keep_ok && own_lt)) begin
               entry_in = new_entry;
            end
         end else begin
            entry_in = prev_link.entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign link.lt = own_lt;
   assign link.entry = entry_ff;
   assign entry = entry_ff;

endmodule

// ----- rtl/bounded_sorted_insert_queue.sv -----
// bounded_sorted_insert_queue: top level, row of bsiq_cell ranks plus
// fill count and response register. Depends on bsiq_pkg and bsiq_cell.
//
// Usage:
//   Request channel (req_valid/req_ready/req_data) carries one command beat:
//   push (insert entry sorted by signed key, newest first among equals,
//   dropping the last rank when full), clear, or read of the entry at a rank.
//   Response channel (rsp_valid/rsp_ready/rsp_data) returns one beat per
//   command with the count after it; a read also returns hit and the entry,
//   zero when the rank is not below the count.
//   The response is valid the cycle after the request beat.
//   Throughput: one command per cycle unless the response stalls; every cell
//   compares with the new key and shifts from its neighbor in the same cycle.
//   A request is taken whenever the response register is empty or is being
//   drained in that cycle; a stalled receiver holds the response and the
//   request side waits.
//   Reset empties the queue (count 0) and the response register; entry
//   storage is not cleared.
module bounded_sorted_insert_queue #(
   parameter int QUEUE_BITS = bsiq_pkg::QUEUE_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bsiq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bsiq_pkg::rsp_type rsp_data
);

   localparam int DEPTH = 1 << QUEUE_BITS;
   localparam int CW = QUEUE_BITS + 1;
   localparam int XW = QUEUE_BITS + bsiq_pkg::RANK_W;

   logic [CW-1:0]       count_ff;
   logic [CW-1:0]       count_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   bsiq_pkg::rsp_type   rsp_ff;
   bsiq_pkg::rsp_type   rsp_in;
   logic                accept;
   logic                push;
   bsiq_pkg::cmd_type   cmd;
   bsiq_pkg::entry_type new_entry;
   bsiq_pkg::link_type  links [DEPTH+1];
   bsiq_pkg::entry_type cells [DEPTH];
   logic [XW-1:0]       rank_x;
   logic [XW-1:0]       count_x;
   logic                hit;

   assign req_ready = !reset && (!rsp_valid_ff || rsp_ready);
   assign accept = req_valid && req_ready;
   assign cmd = bsiq_pkg::cmd_type'(req_data.command);
   assign push = accept && (cmd == bsiq_pkg::CMD_PUSH);

   assign new_entry.key = req_data.key;
   assign new_entry.position = req_data.position;
   assign new_entry.dist_a = req_data.dist_a;
   assign new_entry.dist_b = req_data.dist_b;
   assign new_entry.dist_c = req_data.dist_c;
   assign new_entry.dist_d = req_data.dist_d;

   // rank 0 always sees an upstream key that is smaller
   assign links[0].lt = 1'b1;
   assign links[0].entry = new_entry;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      bsiq_cell u_cell (
         .clock     (clock),
         .push      (push),
         .valid     (count_ff > CW'(i)),
         .keep_ok   (i != DEPTH - 1),
         .new_entry (new_entry),
         .prev_link (links[i]),
         .link      (links[i+1]),
         .entry     (cells[i])
      );
   end

   assign rank_x = XW'(req_data.rank);
   assign count_x = XW'(count_ff);
   assign hit = rank_x < count_x;

   always_comb begin
      count_in = count_ff;
      if (accept) begin
         case (cmd)
            bsiq_pkg::CMD_PUSH: begin
               if (count_ff != CW'(DEPTH)) begin
                  count_in = count_ff + CW'(1);
               end
            end
            bsiq_pkg::CMD_CLEAR: begin
               count_in = '0;
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   always_comb begin
      rsp_in = '0;
      rsp_in.count = bsiq_pkg::COUNT_W'(count_in);
      if ((cmd == bsiq_pkg::CMD_READ) && hit) begin
         rsp_in.hit = 1'b1;
         rsp_in.out_key = cells[rank_x[QUEUE_BITS-1:0]].key;
         rsp_in.out_position = cells[rank_x[QUEUE_BITS-1:0]].position;
         rsp_in.out_dist_a = cells[rank_x[QUEUE_BITS-1:0]].dist_a;
         rsp_in.out_dist_b = cells[rank_x[QUEUE_BITS-1:0]].dist_b;
         rsp_in.out_dist_c = cells[rank_x[QUEUE_BITS-1:0]].dist_c;
         rsp_in.out_dist_d = cells[rank_x[QUEUE_BITS-1:0]].dist_d;
      end
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule
